### rtl/srkl_pkg.sv
// ----------------------------------------------------------------------------
// srkl_pkg
// Shared types and constants for the smallest covering range search block.
// ----------------------------------------------------------------------------
package srkl_pkg;

	localparam int MAX_LISTS  = 8;
	localparam int MAX_LENGTH = 16;
	localparam int LIST_W     = $clog2(MAX_LISTS);
	localparam int POS_W      = $clog2(MAX_LENGTH);
	localparam int ADDR_W     = LIST_W + POS_W;
	localparam int VAL_W      = 32;
	localparam int CNT_W      = 4;
	localparam int LEN_W      = 5;
	localparam int KEY_W      = VAL_W + LIST_W;

	// register indexes on the configuration port
	localparam logic REG_LIST_COUNT  = 1'b0;
	localparam logic REG_LIST_LENGTH = 1'b1;

	typedef struct packed {
		logic                    valid;
		logic signed [VAL_W-1:0] value;
		logic [LIST_W-1:0]       list;
		logic [POS_W-1:0]        pos;
	} head_t;

	typedef struct packed {
		logic clear;
		logic ins;
		logic pop_ins;
	} cell_ctrl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INIT_RD,
		ST_INIT_INS,
		ST_START,
		ST_POP,
		ST_INS,
		ST_OUT
	} state_t;

	// order by value, then list; lists are distinct among heads
	function automatic logic [KEY_W-1:0] head_key(input head_t h);
		head_key = {~h.value[VAL_W-1], h.value[VAL_W-2:0], h.list};
	endfunction

endpackage

### rtl/srkl_store.sv
// ----------------------------------------------------------------------------
// srkl_store
// Element store: one write port for loads, one registered read port.
// ----------------------------------------------------------------------------
module srkl_store import srkl_pkg::*; (
	input  logic                    clk,
	input  logic                    we,
	input  logic [ADDR_W-1:0]       waddr,
	input  logic signed [VAL_W-1:0] wdata,
	input  logic [ADDR_W-1:0]       raddr,
	output logic signed [VAL_W-1:0] rdata
);

	logic signed [VAL_W-1:0] mem_q [MAX_LISTS*MAX_LENGTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

### rtl/srkl_cell.sv
// ----------------------------------------------------------------------------
// srkl_cell
// One slot of the sorted head queue. Compares its head with the broadcast
// entry and takes its own, its neighbor's or the new entry.
// ----------------------------------------------------------------------------
module srkl_cell import srkl_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cell_ctrl_t ctrl,
	input  head_t      x,
	input  logic       first,
	input  head_t      left_head,
	input  logic       left_lt,
	input  head_t      right_head,
	input  logic       right_lt,
	output head_t      head,
	output logic       lt
);

	head_t head_q;
	head_t head_d;

	assign head = head_q;
	assign lt   = head_q.valid && (head_key(head_q) < head_key(x));

	always_comb begin
		head_d = head_q;
		if (ctrl.clear) begin
			head_d.valid = 1'b0;
		end else if (ctrl.ins) begin
			// open a slot: greater entries move one cell right
			if (!lt) begin
				head_d = left_lt ? x : left_head;
			end
		end else if (ctrl.pop_ins) begin
			// drop the front: smaller entries move one cell left
			if (right_lt) begin
				head_d = right_head;
			end else if (lt || first) begin
				head_d = x;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
		end else begin
			head_q <= head_d;
		end
	end

endmodule

### rtl/smallest_range_k_sorted_lists_core.sv
// ----------------------------------------------------------------------------
// smallest_range_k_sorted_lists_core
// Smallest range covering one element of each of several sorted lists.
// ----------------------------------------------------------------------------
// Load items are written to the element store and accepted one per cycle
// while no search runs. The item flagged last starts a search that holds
// one head per list in a row of cells kept sorted by value then list index,
// plus the running maximum. Filling the row takes one store read and one
// insert per list, then a setup step, then for each popped element a compare
// at the front cell and a step that reads the next element and inserts it in
// the same pass that drops the front; the final pop ends the search after its
// compare, and the result is then handed over once the output is free. Pops
// are at most list_count*(list_length-1)+1. The registered store read port
// is why each pop has a compare step apart from its insert step.
// in_stall is high during a search; loads are taken while a result waits.
// ----------------------------------------------------------------------------
module smallest_range_k_sorted_lists_core import srkl_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [2:0]              paddr,
	input  logic [31:0]             pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic signed [VAL_W-1:0] value,
	input  logic [LIST_W-1:0]       list_index,
	input  logic [POS_W-1:0]        position,
	input  logic                    last,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [VAL_W-1:0] range_start,
	output logic signed [VAL_W-1:0] range_end
);

	logic [CNT_W-1:0] list_count_q;
	logic [LEN_W-1:0] list_length_q;
	logic [CNT_W-1:0] k_eff;
	logic [LEN_W-1:0] n_eff;

	state_t state_q, state_d;

	logic                    in_xfer;
	logic                    cfg_wr;
	logic [ADDR_W-1:0]       raddr;
	logic signed [VAL_W-1:0] rdata;
	cell_ctrl_t              cell_ctrl;
	head_t                   x;
	head_t                   heads [MAX_LISTS];
	logic                    lts   [MAX_LISTS];
	logic [MAX_LISTS-1:0]    head_valid;
	head_t                   front;

	logic [CNT_W-1:0]        init_idx_q;
	logic signed [VAL_W-1:0] cur_max_q;
	logic signed [VAL_W-1:0] best_start_q;
	logic signed [VAL_W-1:0] best_end_q;
	logic signed [VAL_W:0]   best_diff_q;
	logic signed [VAL_W:0]   cand_diff;
	logic [LEN_W-1:0]        next_pos;
	logic                    list_done;
	logic                    out_free;
	logic                    out_valid_q;

	// ---------------- configuration port ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			list_count_q  <= CNT_W'(1);
			list_length_q <= LEN_W'(1);
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_LIST_COUNT:  list_count_q  <= pwdata[CNT_W-1:0];
				REG_LIST_LENGTH: list_length_q <= pwdata[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_LIST_COUNT:  prdata = {{(32-CNT_W){1'b0}}, list_count_q};
			REG_LIST_LENGTH: prdata = {{(32-LEN_W){1'b0}}, list_length_q};
			default:         prdata = '0;
		endcase
	end

	always_comb begin
		priority if (list_count_q == '0) begin
			k_eff = CNT_W'(1);
		end else if (list_count_q > CNT_W'(MAX_LISTS)) begin
			k_eff = CNT_W'(MAX_LISTS);
		end else begin
			k_eff = list_count_q;
		end
		priority if (list_length_q == '0) begin
			n_eff = LEN_W'(1);
		end else if (list_length_q > LEN_W'(MAX_LENGTH)) begin
			n_eff = LEN_W'(MAX_LENGTH);
		end else begin
			n_eff = list_length_q;
		end
	end

	// ---------------- load path and store ----------------
	assign in_stall = (state_q != ST_IDLE);
	assign in_xfer  = in_valid && !in_stall;

	srkl_store u_store (
		.clk   (clk),
		.we    (in_xfer),
		.waddr ({list_index, position}),
		.wdata (value),
		.raddr (raddr),
		.rdata (rdata)
	);

	// ---------------- head queue ----------------
	assign front     = heads[0];
	assign next_pos  = {1'b0, front.pos} + LEN_W'(1);
	assign list_done = (next_pos >= n_eff);

	always_comb begin
		x.valid = 1'b1;
		x.value = rdata;
		if (state_q == ST_INIT_INS) begin
			x.list = init_idx_q[LIST_W-1:0];
			x.pos  = '0;
		end else begin
			x.list = front.list;
			x.pos  = next_pos[POS_W-1:0];
		end
	end

	for (genvar i = 0; i < MAX_LISTS; i++) begin : g_cell
		head_t left_head, right_head;
		logic  left_lt, right_lt;

		if (i == 0) begin : g_left_end
			assign left_head = '0;
			assign left_lt   = 1'b1;
		end else begin : g_left
			assign left_head = heads[i-1];
			assign left_lt   = lts[i-1];
		end

		if (i == MAX_LISTS - 1) begin : g_right_end
			assign right_head = '0;
			assign right_lt   = 1'b0;
		end else begin : g_right
			assign right_head = heads[i+1];
			assign right_lt   = lts[i+1];
		end

		srkl_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (cell_ctrl),
			.x          (x),
			.first      (i == 0),
			.left_head  (left_head),
			.left_lt    (left_lt),
			.right_head (right_head),
			.right_lt   (right_lt),
			.head       (heads[i]),
			.lt         (lts[i])
		);

		assign head_valid[i] = heads[i].valid;
	end

	// ---------------- sequencer ----------------
	assign out_free  = !out_valid_q || !out_stall;
	assign cand_diff = {cur_max_q[VAL_W-1], cur_max_q} - {front.value[VAL_W-1], front.value};

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_xfer && last) begin
					state_d = ST_INIT_RD;
				end
			end
			ST_INIT_RD:  state_d = ST_INIT_INS;
			ST_INIT_INS: begin
				state_d = (init_idx_q + CNT_W'(1) == k_eff) ? ST_START : ST_INIT_RD;
			end
			ST_START:    state_d = ST_POP;
			ST_POP:      state_d = list_done ? ST_OUT : ST_INS;
			ST_INS:      state_d = ST_POP;
			ST_OUT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default:     state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cell_ctrl = '0;
		raddr     = {front.list, next_pos[POS_W-1:0]};
		unique case (state_q)
			ST_IDLE:     cell_ctrl.clear = in_xfer && last;
			ST_INIT_RD:  raddr = {init_idx_q[LIST_W-1:0], {POS_W{1'b0}}};
			ST_INIT_INS: cell_ctrl.ins = 1'b1;
			ST_INS:      cell_ctrl.pop_ins = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// ---------------- search datapath ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_idx_q   <= '0;
			cur_max_q    <= '0;
			best_start_q <= '0;
			best_end_q   <= '0;
			best_diff_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					init_idx_q <= '0;
				end
				ST_INIT_INS: begin
					init_idx_q <= init_idx_q + CNT_W'(1);
					if (init_idx_q == '0 || rdata > cur_max_q) begin
						cur_max_q <= rdata;
					end
				end
				ST_START: begin
					best_start_q <= front.value;
					best_end_q   <= cur_max_q;
					best_diff_q  <= cand_diff;
				end
				ST_POP: begin
					// narrow only on a strictly smaller span
					if (cand_diff < best_diff_q) begin
						best_start_q <= front.value;
						best_end_q   <= cur_max_q;
						best_diff_q  <= cand_diff;
					end
				end
				ST_INS: begin
					if (rdata > cur_max_q) begin
						cur_max_q <= rdata;
					end
				end
				default: ;
			endcase
		end
	end

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free) begin
			range_start <= best_start_q;
			range_end   <= best_end_q;
		end
	end

	assign out_valid = out_valid_q;

	// ---------------- assertions ----------------
	a_queue_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_POP) |-> ($countones(head_valid) == int'(k_eff)))
		else $error("head queue does not hold one head per list");

	a_front_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_INS) |-> front.valid)
		else $error("pop with an empty front cell");

	a_span_sign: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_POP) |-> !best_diff_q[VAL_W])
		else $error("best span went negative");

	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_OUT))
		else $error("result raised outside the hand-over state");

endmodule
